[hw/rtl/lcs_pkg.sv]
package lcs_pkg;

    // sketch geometry
    localparam int BUCKET_W  = 16;
    localparam int COUNT_W   = 17;
    localparam int KEY_W     = 64;
    localparam int SEED_W    = 32;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0]  MAX_BUCKETS   = COUNT_W'(65536);
    localparam logic [LEN_W-1:0]    MAX_KEY_BYTES = LEN_W'(8);
    localparam logic [BUCKET_W-1:0] LAST_BUCKET   = '1;

    // murmur2 mixing constant
    localparam logic [31:0] MM_MUL = 32'h5bd1e995;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED = CFG_IDX_W'(2);

    // settings seen by the hash front end
    typedef struct packed {
        logic [SEED_W-1:0]  seed;
        logic [LEN_W-1:0]   key_bytes;
        logic [COUNT_W-1:0] width;
    } front_cfg_t;

    // control from the register bank to the bitmap back end
    typedef struct packed {
        logic               clear_req;
        logic [COUNT_W-1:0] width;
    } back_ctl_t;

    // one finished result
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                newly_set;
        logic [COUNT_W-1:0]  zeros_left;
        logic                map_full;
    } result_t;

endpackage

[hw/rtl/lcs_front.sv]
module lcs_front
    import lcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  front_cfg_t          cfg,
    input  logic                take,
    input  logic [KEY_W-1:0]    key_value,
    output logic                idle,
    input  logic                mid_full,
    output logic                mid_push,
    output logic [BUCKET_W-1:0] mid_bucket
);

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_KMUL1 = 7'b0000010,
        F_KMUL2 = 7'b0000100,
        F_HMIX  = 7'b0001000,
        F_TAIL  = 7'b0010000,
        F_FIN   = 7'b0100000,
        F_BKT   = 7'b1000000
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [31:0]         h_reg;
    logic [31:0]         k_reg;
    logic                blk_reg;
    logic [LEN_W-1:0]    len_in;
    logic [1:0]          nblocks;
    logic [1:0]          rem;
    logic [31:0]         word_k;
    logic [31:0]         word_t;
    logic [31:0]         tail_mask;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         product;

    // key length clamp at accept
    assign len_in  = (cfg.key_bytes > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cfg.key_bytes;
    assign nblocks = len_reg[3:2];
    assign rem     = len_reg[1:0];

    // 32-bit words of the key, for whole blocks and for the tail
    assign word_k = blk_reg    ? key_reg[63:32] : key_reg[31:0];
    assign word_t = len_reg[2] ? key_reg[63:32] : key_reg[31:0];

    always_comb
    begin
        case (rem)
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    // one shared multiplier, operands picked by the step
    always_comb
    begin
        mul_b = MM_MUL;
        case (state_reg)
            F_KMUL1: mul_a = word_k;
            F_KMUL2: mul_a = k_reg ^ (k_reg >> 24);
            F_HMIX:  mul_a = h_reg;
            F_TAIL:  mul_a = h_reg ^ (word_t & tail_mask);
            F_FIN:   mul_a = h_reg ^ (h_reg >> 13);
            F_BKT:
            begin
                mul_a = h_reg ^ (h_reg >> 15);
                mul_b = 32'(cfg.width);
            end
            default: mul_a = h_reg;
        endcase
    end

    assign product = 64'(mul_a) * 64'(mul_b);

    // step sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    state_next = (len_in[3:2] != 2'd0) ? F_KMUL1 : F_TAIL;
                end
            end
            F_KMUL1: state_next = F_KMUL2;
            F_KMUL2: state_next = F_HMIX;
            F_HMIX:
            begin
                if (!blk_reg && nblocks == 2'd2)
                begin
                    state_next = F_KMUL1;
                end
                else
                begin
                    state_next = F_TAIL;
                end
            end
            F_TAIL:  state_next = F_FIN;
            F_FIN:   state_next = F_BKT;
            F_BKT:
            begin
                if (!mid_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hash datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    key_reg <= key_value;
                    len_reg <= len_in;
                    h_reg   <= cfg.seed ^ 32'(len_in);
                    blk_reg <= 1'b0;
                end
            end
            F_KMUL1: k_reg <= product[31:0];
            F_KMUL2: k_reg <= product[31:0];
            F_HMIX:
            begin
                h_reg   <= product[31:0] ^ k_reg;
                blk_reg <= 1'b1;
            end
            F_TAIL:
            begin
                if (rem != 2'd0)
                begin
                    h_reg <= product[31:0];
                end
            end
            F_FIN:   h_reg <= product[31:0];
            default: ;
        endcase
    end

    // bucket = (hash * width) >> 32, width never above 2^16
    assign idle       = (state_reg == F_IDLE);
    assign mid_push   = (state_reg == F_BKT) && !mid_full;
    assign mid_bucket = product[47:32];

endmodule

[hw/rtl/lcs_mid_queue.sv]
module lcs_mid_queue
    import lcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [BUCKET_W-1:0] push_bucket,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output logic [BUCKET_W-1:0] head_bucket
);

    logic [BUCKET_W-1:0] slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;

    assign full        = (count_reg == 2'd2);
    assign empty       = (count_reg == 2'd0);
    assign head_bucket = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bucket;
        end
    end

endmodule

[hw/rtl/lcs_back.sv]
module lcs_back
    import lcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  back_ctl_t           ctl,
    output logic                clearing,
    input  logic                mid_empty,
    input  logic [BUCKET_W-1:0] mid_bucket,
    output logic                mid_pop,
    output logic                empty,
    input  logic                pop,
    output result_t             result
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_UPD   = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [BUCKET_W-1:0] clr_addr_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [COUNT_W-1:0]  zero_count_reg, zero_count_next;
    logic                bitmap [2**BUCKET_W];
    logic                rd_bit_reg;
    logic                start;
    logic                fresh;
    result_t             out_slot_reg [2];
    result_t             new_result;
    logic                out_wr_reg;
    logic                out_rd_reg;
    logic [1:0]          out_count_reg;
    logic                out_push;

    assign clearing = (state_reg == B_CLEAR);
    assign start    = (state_reg == B_IDLE) && !mid_empty && (out_count_reg != 2'd2);
    assign mid_pop  = start;
    assign fresh    = (state_reg == B_UPD) && !rd_bit_reg;
    assign out_push = (state_reg == B_UPD);

    // zero bucket count after this transaction
    always_comb
    begin
        zero_count_next = zero_count_reg;
        if (fresh && zero_count_reg != '0)
        begin
            zero_count_next = zero_count_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == LAST_BUCKET)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (start)
                begin
                    state_next = B_UPD;
                end
            end
            B_UPD:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
        if (ctl.clear_req)
        begin
            state_next = B_CLEAR;
        end
    end

    // control state, clear sweep and zero count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            clr_addr_reg   <= '0;
            zero_count_reg <= MAX_BUCKETS;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clear_req)
            begin
                clr_addr_reg   <= '0;
                zero_count_reg <= ctl.width;
            end
            else
            begin
                if (state_reg == B_CLEAR)
                begin
                    clr_addr_reg <= clr_addr_reg + BUCKET_W'(1);
                end
                zero_count_reg <= zero_count_next;
            end
        end
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR)
        begin
            bitmap[clr_addr_reg] <= 1'b0;
        end
        else if (fresh)
        begin
            bitmap[bucket_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_bit_reg <= bitmap[mid_bucket];
        if (start)
        begin
            bucket_reg <= mid_bucket;
        end
    end

    // result queue
    always_comb
    begin
        new_result.bucket     = bucket_reg;
        new_result.newly_set  = fresh;
        new_result.zeros_left = zero_count_next;
        new_result.map_full   = (zero_count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            if (out_push)
            begin
                out_wr_reg <= !out_wr_reg;
            end
            if (pop && !empty)
            begin
                out_rd_reg <= !out_rd_reg;
            end
            if (out_push && !(pop && !empty))
            begin
                out_count_reg <= out_count_reg + 2'd1;
            end
            else if (!out_push && pop && !empty)
            begin
                out_count_reg <= out_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_slot_reg[out_wr_reg] <= new_result;
        end
    end

    assign empty  = (out_count_reg == 2'd0);
    assign result = out_slot_reg[out_rd_reg];

endmodule

[hw/rtl/linear_counting_sketch_core.sv]
// linear counting cardinality sketch
// input channel: drive key_value with push high; the key is taken at a clock
//   edge where push is high and full is low
// result channel: while empty is low, bucket, newly_set, zeros_left and
//   map_full show the oldest result; pop high at a clock edge takes it
// config port: cfg_write with cfg_index (0 map_width, 1 key_bytes,
//   2 hash_seed) and cfg_data, written at the clock edge; the user must
//   write only while idle, which the block itself leaves unchecked
// the hash front end runs murmur2 on one shared 32x32 multiplier, one
//   multiply step per cycle unless a full queue holds the bucket step:
//   two key multiplies and a hash mix per whole 4-byte block, then tail,
//   finalise and bucket steps, key_bytes clamped to 8; that sequence sets
//   the sustained rate; a bitmap read-modify-write then yields the result
// reset and every map_width write start a clearing pass over the whole
//   bitmap; full stays high during the pass
// a stalled receiver fills the 2-entry result queue and then the 2-entry
//   queue between hash and bitmap, after which the hash front end holds in
//   its last step and full stays high
module linear_counting_sketch_core
    import lcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [KEY_W-1:0]      key_value,
    output logic                  empty,
    input  logic                  pop,
    output logic [BUCKET_W-1:0]   bucket,
    output logic                  newly_set,
    output logic [COUNT_W-1:0]    zeros_left,
    output logic                  map_full
);

    logic [COUNT_W-1:0]  map_width_reg;
    logic [LEN_W-1:0]    key_bytes_reg;
    logic [SEED_W-1:0]   hash_seed_reg;
    logic                clear_req_reg;
    logic [COUNT_W-1:0]  eff_width;
    front_cfg_t          front_cfg;
    back_ctl_t           back_ctl;
    logic                front_idle;
    logic                clearing;
    logic                take;
    logic                mid_push;
    logic                mid_pop;
    logic                mid_full;
    logic                mid_empty;
    logic [BUCKET_W-1:0] push_bucket;
    logic [BUCKET_W-1:0] head_bucket;
    result_t             result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg <= MAX_BUCKETS;
            key_bytes_reg <= MAX_KEY_BYTES;
            hash_seed_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH: map_width_reg <= cfg_data[COUNT_W-1:0];
                CFG_KEY_BYTES: key_bytes_reg <= cfg_data[LEN_W-1:0];
                CFG_HASH_SEED: hash_seed_reg <= cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    // width in use: zero counts as one, clamp at the bitmap size
    always_comb
    begin
        if (map_width_reg == '0)
        begin
            eff_width = COUNT_W'(1);
        end
        else if (map_width_reg > MAX_BUCKETS)
        begin
            eff_width = MAX_BUCKETS;
        end
        else
        begin
            eff_width = map_width_reg;
        end
    end

    assign front_cfg.seed      = hash_seed_reg;
    assign front_cfg.key_bytes = key_bytes_reg;
    assign front_cfg.width     = eff_width;

    // clear request follows a width write, when the new width is in place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_req_reg <= 1'b0;
        end
        else
        begin
            clear_req_reg <= cfg_write && (cfg_index == CFG_MAP_WIDTH);
        end
    end

    assign back_ctl.clear_req = clear_req_reg;
    assign back_ctl.width     = eff_width;

    // input handshake
    assign full = !front_idle || clearing || clear_req_reg;
    assign take = push && !full;

    lcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (front_cfg),
        .take       (take),
        .key_value  (key_value),
        .idle       (front_idle),
        .mid_full   (mid_full),
        .mid_push   (mid_push),
        .mid_bucket (push_bucket)
    );

    lcs_mid_queue u_mid_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (mid_push),
        .push_bucket (push_bucket),
        .full        (mid_full),
        .pop         (mid_pop),
        .empty       (mid_empty),
        .head_bucket (head_bucket)
    );

    lcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (back_ctl),
        .clearing   (clearing),
        .mid_empty  (mid_empty),
        .mid_bucket (head_bucket),
        .mid_pop    (mid_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign bucket     = result.bucket;
    assign newly_set  = result.newly_set;
    assign zeros_left = result.zeros_left;
    assign map_full   = result.map_full;

endmodule

[bench/tb_linear_counting_sketch_core.sv]
module tb_linear_counting_sketch_core
    import lcs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0]          MIX_MUL        = 32'h5bd1e995;
    localparam logic [COUNT_W-1:0]   BUCKET_COUNT   = 17'd65536;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam int                   KEY_BYTES_MAX  = 8;
    localparam int                   TIMEOUT_CYCLES = 4_000_000;
    localparam int                   SETTLE_CYCLES  = 16;
    localparam int                   RECENT_DEPTH   = 32;
    localparam int                   PHASE_KEYS     = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [KEY_W-1:0]      key_value = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [BUCKET_W-1:0]   bucket;
    logic                  newly_set;
    logic [COUNT_W-1:0]    zeros_left;
    logic                  map_full;

    // predictor state: bitmap, zero count and register copies
    bit                    model_bitmap [65536];
    logic [COUNT_W-1:0]    model_zeros;
    logic [COUNT_W-1:0]    model_width;
    logic [LEN_W-1:0]      model_key_bytes;
    logic [SEED_W-1:0]     model_seed;

    result_t               sketch_results_q [$];
    logic [KEY_W-1:0]      recent_keys [$];
    int unsigned           sender_idle_pct = 23;
    int unsigned           receiver_idle_pct = 66;
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;

    linear_counting_sketch_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .key_value  (key_value),
        .empty      (empty),
        .pop        (pop),
        .bucket     (bucket),
        .newly_set  (newly_set),
        .zeros_left (zeros_left),
        .map_full   (map_full)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("tb_linear_counting_sketch_core NOT OK");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // murmur2 over the low len bytes of the key
    function automatic logic [31:0] murmur2_hash(input logic [KEY_W-1:0] key,
                                                 input int unsigned len,
                                                 input logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        int unsigned i;
        h = seed ^ 32'(len);
        i = 0;
        while (len - i >= 4)
        begin
            k = key[8*i +: 32];
            k = k * MIX_MUL;
            k = k ^ (k >> 24);
            k = k * MIX_MUL;
            h = h * MIX_MUL;
            h = h ^ k;
            i = i + 4;
        end
        // tail bytes
        if (len - i == 3)
            h = h ^ (32'(key[8*(i+2) +: 8]) << 16);
        if (len - i >= 2)
            h = h ^ (32'(key[8*(i+1) +: 8]) << 8);
        if (len - i >= 1)
        begin
            h = h ^ 32'(key[8*i +: 8]);
            h = h * MIX_MUL;
        end
        h = h ^ (h >> 13);
        h = h * MIX_MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    // width zero acts as one, oversize acts as the full map
    function automatic logic [COUNT_W-1:0] used_width(input logic [COUNT_W-1:0] w);
        if (w == '0)
            return COUNT_W'(1);
        if (w > BUCKET_COUNT)
            return BUCKET_COUNT;
        return w;
    endfunction

    // hash, pick the bucket, mark it and queue the expected transaction
    task automatic predict_sketch_update(input logic [KEY_W-1:0] key);
        logic [31:0]         h;
        logic [63:0]         product;
        int unsigned         len;
        result_t             r;
        len = (model_key_bytes > KEY_BYTES_MAX) ? KEY_BYTES_MAX : model_key_bytes;
        h = murmur2_hash(key, len, model_seed);
        product = 64'(h) * 64'(used_width(model_width));
        r.bucket = product[47:32];
        r.newly_set = 1'b0;
        if (!model_bitmap[r.bucket])
        begin
            model_bitmap[r.bucket] = 1'b1;
            if (model_zeros != '0)
                model_zeros = model_zeros - COUNT_W'(1);
            r.newly_set = 1'b1;
        end
        r.zeros_left = model_zeros;
        r.map_full = (model_zeros == '0);
        sketch_results_q.push_back(r);
    endtask

    // register write, mirrored into the predictor
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MAP_WIDTH:
            begin
                model_width = data[COUNT_W-1:0];
                foreach (model_bitmap[i])
                    model_bitmap[i] = 1'b0;
                model_zeros = used_width(model_width);
            end
            CFG_KEY_BYTES: model_key_bytes = data[LEN_W-1:0];
            CFG_HASH_SEED: model_seed = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one key transaction, with a random idle gap ahead of it
    task automatic send_key(input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        key_value <= key;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_sketch_update(key);
        recent_keys.push_back(key);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endtask

    // stop sending and let every expected transaction come out
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (sketch_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // compare each popped transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (sketch_results_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none actual bucket %0d",
                         $time, bucket);
            end
            else
            begin
                want = sketch_results_q.pop_front();
                check_field("bucket", 32'(want.bucket), 32'(bucket));
                check_field("newly_set", 32'(want.newly_set), 32'(newly_set));
                check_field("zeros_left", 32'(want.zeros_left), 32'(zeros_left));
                check_field("map_full", 32'(want.map_full), 32'(map_full));
            end
        end
    end

    // default registers right after reset, edge-case key patterns
    task automatic test_reset_defaults();
        send_key('0);
        send_key('1);
        send_key({32{2'b10}});
        send_key({32{2'b01}});
        drain_results();
    endtask

    // every key length, plus empty key and oversize length
    task automatic test_key_lengths();
        for (int kb = 0; kb <= 9; kb++)
        begin
            write_register(CFG_KEY_BYTES,
                           {28'($urandom), (kb == 9) ? 4'd15 : 4'(kb)});
            send_key({$urandom, $urandom});
            drain_results();
        end
        write_register(CFG_HASH_SEED, 32'hffff_ffff);
    endtask

    // one bucket map fills on the first key; width zero behaves the same
    task automatic test_single_bucket();
        write_register(CFG_HASH_SEED, $urandom);
        write_register(CFG_MAP_WIDTH, {15'($urandom), 17'd1});
        repeat (3) send_key({$urandom, $urandom});
        drain_results();
        write_register(CFG_MAP_WIDTH, {15'($urandom), 17'd0});
        repeat (2) send_key({$urandom, $urandom});
        drain_results();
    endtask

    // unused index is ignored, all-ones width clamps to the full map
    task automatic test_width_overrange();
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        write_register(CFG_UNUSED, $urandom);
        write_register(CFG_MAP_WIDTH, 32'hffff_ffff);
        send_key(key);
        send_key(key);
        drain_results();
    endtask

    // random keys, some repeated, under one map width and two hash settings
    task automatic run_random_phase(input int unsigned s_pct, input int unsigned r_pct,
                                    input logic [COUNT_W-1:0] width);
        logic [KEY_W-1:0] key;
        sender_idle_pct = s_pct;
        receiver_idle_pct = r_pct;
        for (int half = 0; half < 2; half++)
        begin
            write_register(CFG_KEY_BYTES, {28'($urandom), 4'($urandom_range(15))});
            write_register(CFG_HASH_SEED, $urandom);
            if (half == 0)
                write_register(CFG_MAP_WIDTH, {15'($urandom), width});
            for (int i = 0; i < PHASE_KEYS / 2; i++)
            begin
                if (recent_keys.size() != 0 && $urandom_range(3) == 0)
                    key = recent_keys[$urandom_range(recent_keys.size() - 1)];
                else
                    key = {$urandom, $urandom};
                send_key(key);
            end
            drain_results();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(23, 66, 17'($urandom_range(24, 2)));
        run_random_phase(23, 66, 17'($urandom_range(65536, 100)));
        run_random_phase(66, 23, 17'($urandom_range(300, 2)));
        run_random_phase(66, 23, BUCKET_COUNT);
        run_random_phase(0, 0, 17'($urandom_range(60, 25)));
        run_random_phase(0, 0, 17'($urandom_range(4000, 301)));
    endtask

    initial
    begin
        model_width = BUCKET_COUNT;
        model_key_bytes = 4'd8;
        model_seed = '0;
        model_zeros = BUCKET_COUNT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_key_lengths();
        test_single_bucket();
        test_width_overrange();
        test_random_traffic();

        if (error_count == 0)
            $display("tb_linear_counting_sketch_core OK");
        else
            $display("tb_linear_counting_sketch_core NOT OK");
        $finish;
    end

endmodule

[linear_counting_sketch_core.f]
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_front.sv
hw/rtl/lcs_mid_queue.sv
hw/rtl/lcs_back.sv
hw/rtl/linear_counting_sketch_core.sv
bench/tb_linear_counting_sketch_core.sv
